// File: sv/sswl_pkg.sv
package sswl_pkg;

    // Input modes
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_BEGIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OUTCOME = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON      = 1'd1;
    localparam int CFG_DATA_W = 16;

    // Field widths
    localparam int GEN_W   = 16;
    localparam int LP_W    = 7;
    localparam int EPS_W   = 16;
    localparam int CNT_W   = 11;   // one ring count
    localparam int TOT_W   = 17;   // one running total
    localparam int PROB_W  = 17;   // Q0.16 with room for one
    localparam int WGT_W   = 17;   // ratio plus epsilon
    localparam int FRAC_W  = 16;

    // Saturation limits and reset values
    localparam logic [CNT_W-1:0] RING_MAX  = 11'd2047;
    localparam logic [TOT_W-1:0] TOTAL_MAX = 17'd131071;
    localparam int ONE_Q16 = 65536;
    localparam logic [LP_W-1:0]  LP_RESET  = 7'd50;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd655;

    // Shared divider: numerator width and quotient bits produced per run
    localparam int DIV_NUM_W = 34;
    localparam int DIV_Q_W   = 17;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    // Sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] ST_DIV    = 4'd1;
    localparam logic [ST_W-1:0] ST_BSLOT  = 4'd2;
    localparam logic [ST_W-1:0] ST_BRD    = 4'd3;
    localparam logic [ST_W-1:0] ST_BSUB   = 4'd4;
    localparam logic [ST_W-1:0] ST_ORD    = 4'd5;
    localparam logic [ST_W-1:0] ST_OWR    = 4'd6;
    localparam logic [ST_W-1:0] ST_RSETUP = 4'd7;
    localparam logic [ST_W-1:0] ST_RDONE  = 4'd8;
    localparam logic [ST_W-1:0] ST_PSETUP = 4'd9;
    localparam logic [ST_W-1:0] ST_PDONE  = 4'd10;
    localparam logic [ST_W-1:0] ST_EMIT   = 4'd11;

    typedef logic [ST_W-1:0] t_state;

endpackage

// File: sv/sswl_ram.sv
module sswl_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/strategy_success_window_learner_core.sv
// The shared 17-step restoring divider does mod (begin-generation), ratio and normalize
// (compute). Before the window fills, compute only emits; with a full window it divides a
// ratio per strategy with counts, gives an empty strategy epsilon alone and normalizes
// unless every weight is zero. Beats run back to back; the receiver cannot stall.
// Synchronous active-low reset restores config defaults, totals, probabilities, slot valid bits.
module strategy_success_window_learner_core #(
    parameter int NUM_STRATEGIES = 4,
    parameter int MAX_PERIOD     = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // command channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic [sswl_pkg::MODE_W-1:0]            i_mode,
    input  logic [sswl_pkg::GEN_W-1:0]             i_generation,
    input  logic [$clog2(NUM_STRATEGIES)-1:0]      i_strategy,
    input  logic                                   i_succeeded,
    // result channel
    output logic                                   o_valid,
    output logic [$clog2(NUM_STRATEGIES)-1:0]      o_strategy_index,
    output logic [sswl_pkg::PROB_W-1:0]            o_probability,
    output logic                                   o_last,
    // configuration channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sswl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sswl_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    import sswl_pkg::*;

    localparam int IW   = $clog2(NUM_STRATEGIES);
    localparam int SLW  = $clog2(MAX_PERIOD);
    localparam int PUW  = $clog2(MAX_PERIOD + 1);
    localparam int SUMW = TOT_W + $clog2(NUM_STRATEGIES);
    localparam int DW   = SUMW;
    localparam int RW   = 2 * NUM_STRATEGIES * CNT_W;

    // Configuration
    logic [LP_W-1:0]  r_lp;
    logic [EPS_W-1:0] r_eps;

    // Sequencer
    t_state r_state, n_state;
    t_state r_ret;
    logic [IW-1:0]  r_idx;
    logic           r_succ;
    logic [GEN_W-1:0] r_gen;
    logic [SLW-1:0] r_slot;

    // Shared divider
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_dvs;
    logic [DIV_Q_W-1:0]   r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;

    // Totals, weights, probabilities
    logic [TOT_W-1:0]  r_succ_tot [NUM_STRATEGIES];
    logic [TOT_W-1:0]  r_fail_tot [NUM_STRATEGIES];
    logic [WGT_W-1:0]  r_weight   [NUM_STRATEGIES];
    logic [PROB_W-1:0] r_prob     [NUM_STRATEGIES];
    logic [SUMW-1:0]   r_sum;
    logic [MAX_PERIOD-1:0] r_row_valid;

    // Output register
    logic              r_out_valid;
    logic [IW-1:0]     r_out_idx;
    logic [PROB_W-1:0] r_out_prob;
    logic              r_out_last;

    // RAM port
    logic          ram_we;
    logic          ram_re;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;

    logic                 accept;
    logic [PUW-1:0]       p_used;
    logic                 in_strat_ok;
    logic                 in_full;
    logic                 idx_last;
    logic [TOT_W-1:0]     s_sel;
    logic [TOT_W-1:0]     f_sel;
    logic [TOT_W:0]       den;
    logic                 den_zero;
    logic [WGT_W-1:0]     w_new;
    logic [SUMW-1:0]      sum_next;
    logic                 div_ld;
    logic [DIV_NUM_W-1:0] div_ld_num;
    logic [DW-1:0]        div_ld_dvs;
    logic [DW:0]          div_trial;
    logic [DW:0]          div_diff;
    logic                 div_ge;
    logic [RW-1:0]        row_cur;
    logic [CNT_W-1:0]     row_cnt;
    int                   row_fi;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Window length clamped to 1..MAX_PERIOD
    always_comb begin
        if (r_lp == '0) begin
            p_used = PUW'(1);
        end else if (int'(r_lp) > MAX_PERIOD) begin
            p_used = PUW'(MAX_PERIOD);
        end else begin
            p_used = PUW'(r_lp);
        end
    end

    assign in_strat_ok = (int'(i_strategy) < NUM_STRATEGIES);
    assign in_full     = (int'(i_generation) >= int'(p_used));
    assign idx_last    = (r_idx == IW'(NUM_STRATEGIES - 1));

    // Per-strategy ratio inputs
    assign s_sel    = r_succ_tot[r_idx];
    assign f_sel    = r_fail_tot[r_idx];
    assign den      = {1'b0, s_sel} + {1'b0, f_sel};
    assign den_zero = (den == '0);
    assign w_new    = (r_state == ST_RDONE) ? (r_quo + WGT_W'(r_eps)) : WGT_W'(r_eps);
    assign sum_next = r_sum + SUMW'(w_new);

    // Divider load: mod, ratio or normalize
    always_comb begin
        div_ld     = 1'b0;
        div_ld_num = '0;
        div_ld_dvs = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_mode == MODE_BEGIN) begin
                    div_ld     = 1'b1;
                    div_ld_num = DIV_NUM_W'(i_generation);
                    div_ld_dvs = DW'(p_used);
                end
            end
            ST_RSETUP: begin
                if (!den_zero) begin
                    div_ld     = 1'b1;
                    div_ld_num = DIV_NUM_W'({s_sel, {FRAC_W{1'b0}}});
                    div_ld_dvs = DW'(den);
                end
            end
            ST_PSETUP: begin
                div_ld     = 1'b1;
                div_ld_num = DIV_NUM_W'({r_weight[r_idx], {FRAC_W{1'b0}}})
                           + DIV_NUM_W'(r_sum >> 1);
                div_ld_dvs = r_sum;
            end
            default: begin
                div_ld = 1'b0;
            end
        endcase
    end

    // One restoring step
    assign div_trial = {r_rem, r_quo[DIV_Q_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_dvs});
    assign div_diff  = div_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (div_ld) begin
            r_rem <= DW'(div_ld_num[DIV_NUM_W-1:DIV_Q_W]);
            r_quo <= div_ld_num[DIV_Q_W-1:0];
            r_dvs <= div_ld_dvs;
        end else if (r_state == ST_DIV) begin
            r_rem <= div_ge ? div_diff[DW-1:0] : div_trial[DW-1:0];
            r_quo <= {r_quo[DIV_Q_W-2:0], div_ge};
        end
    end

    // Ring row read-modify for an outcome
    always_comb begin
        row_cur   = r_row_valid[r_slot] ? ram_rdata : '0;
        row_fi    = r_succ ? int'(r_idx) : NUM_STRATEGIES + int'(r_idx);
        row_cnt   = row_cur[row_fi*CNT_W +: CNT_W];
        ram_wdata = row_cur;
        if (row_cnt != RING_MAX) begin
            ram_wdata[row_fi*CNT_W +: CNT_W] = row_cnt + CNT_W'(1);
        end
    end

    assign ram_re = (r_state == ST_BRD) || (r_state == ST_ORD);
    assign ram_we = (r_state == ST_OWR);

    sswl_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (r_slot),
        .i_wr_data (ram_wdata),
        .i_re      (ram_re),
        .i_rd_addr (r_slot),
        .o_rd_data (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_BEGIN:   n_state = ST_DIV;
                        MODE_OUTCOME: n_state = in_strat_ok ? ST_ORD : ST_IDLE;
                        MODE_COMPUTE: n_state = in_full ? ST_RSETUP : ST_EMIT;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:   n_state = (r_cnt == '0) ? r_ret : ST_DIV;
            ST_BSLOT: n_state = ST_BRD;
            ST_BRD:   n_state = ST_BSUB;
            ST_BSUB:  n_state = ST_IDLE;
            ST_ORD:   n_state = ST_OWR;
            ST_OWR:   n_state = ST_IDLE;
            ST_RSETUP: begin
                if (!den_zero) begin
                    n_state = ST_DIV;
                end else if (idx_last) begin
                    n_state = (sum_next == '0) ? ST_EMIT : ST_PSETUP;
                end else begin
                    n_state = ST_RSETUP;
                end
            end
            ST_RDONE: begin
                if (idx_last) begin
                    n_state = (sum_next == '0) ? ST_EMIT : ST_PSETUP;
                end else begin
                    n_state = ST_RSETUP;
                end
            end
            ST_PSETUP: n_state = ST_DIV;
            ST_PDONE:  n_state = idx_last ? ST_EMIT : ST_PSETUP;
            ST_EMIT:   n_state = idx_last ? ST_IDLE : ST_EMIT;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_idx       <= '0;
            r_slot      <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_lp        <= LP_RESET;
            r_eps       <= EPS_RESET;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < NUM_STRATEGIES; s++) begin
                r_succ_tot[s] <= '0;
                r_fail_tot[s] <= '0;
                r_prob[s]     <= PROB_W'(ONE_Q16 / NUM_STRATEGIES);
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == ST_EMIT);

            // Config writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEARN_PERIOD: r_lp  <= i_cfg_data[LP_W-1:0];
                    CFG_EPSILON:      r_eps <= i_cfg_data[EPS_W-1:0];
                    default:          r_lp  <= r_lp;
                endcase
            end

            // Divider step count
            if (div_ld) begin
                r_cnt <= DIV_CNT_W'(DIV_Q_W - 1);
            end else if (r_state == ST_DIV && r_cnt != '0) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_mode)
                            MODE_BEGIN:   r_ret <= ST_BSLOT;
                            MODE_OUTCOME: r_idx <= i_strategy;
                            MODE_COMPUTE: begin
                                r_idx <= '0;
                                r_sum <= '0;
                            end
                            default: r_ret <= ST_IDLE;
                        endcase
                    end
                end
                ST_BSLOT: r_slot <= r_rem[SLW-1:0];
                ST_BSUB: begin
                    // Drop the slot's counts once the window is full, then empty it
                    if (int'(r_gen) >= int'(p_used)) begin
                        for (int s = 0; s < NUM_STRATEGIES; s++) begin
                            if (TOT_W'(row_cur[s*CNT_W +: CNT_W]) > r_succ_tot[s]) begin
                                r_succ_tot[s] <= '0;
                            end else begin
                                r_succ_tot[s] <= r_succ_tot[s]
                                               - TOT_W'(row_cur[s*CNT_W +: CNT_W]);
                            end
                            if (TOT_W'(row_cur[(NUM_STRATEGIES+s)*CNT_W +: CNT_W])
                                    > r_fail_tot[s]) begin
                                r_fail_tot[s] <= '0;
                            end else begin
                                r_fail_tot[s] <= r_fail_tot[s]
                                    - TOT_W'(row_cur[(NUM_STRATEGIES+s)*CNT_W +: CNT_W]);
                            end
                        end
                    end
                    r_row_valid[r_slot] <= 1'b0;
                end
                ST_OWR: begin
                    r_row_valid[r_slot] <= 1'b1;
                    if (r_succ) begin
                        if (r_succ_tot[r_idx] != TOTAL_MAX) begin
                            r_succ_tot[r_idx] <= r_succ_tot[r_idx] + TOT_W'(1);
                        end
                    end else begin
                        if (r_fail_tot[r_idx] != TOTAL_MAX) begin
                            r_fail_tot[r_idx] <= r_fail_tot[r_idx] + TOT_W'(1);
                        end
                    end
                end
                ST_RSETUP: begin
                    if (!den_zero) begin
                        r_ret <= ST_RDONE;
                    end else begin
                        r_sum <= sum_next;
                        r_idx <= idx_last ? '0 : r_idx + IW'(1);
                    end
                end
                ST_RDONE: begin
                    r_sum <= sum_next;
                    r_idx <= idx_last ? '0 : r_idx + IW'(1);
                end
                ST_PSETUP: r_ret <= ST_PDONE;
                ST_PDONE: begin
                    r_prob[r_idx] <= r_quo;
                    r_idx         <= idx_last ? '0 : r_idx + IW'(1);
                end
                ST_EMIT: r_idx <= idx_last ? '0 : r_idx + IW'(1);
                default: r_idx <= r_idx;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_gen  <= i_generation;
            r_succ <= i_succeeded;
        end
        if ((r_state == ST_RSETUP && den_zero) || r_state == ST_RDONE) begin
            r_weight[r_idx] <= w_new;
        end
        r_out_idx  <= r_idx;
        r_out_prob <= r_prob[r_idx];
        r_out_last <= idx_last;
    end

    assign o_valid          = r_out_valid;
    assign o_strategy_index = r_out_idx;
    assign o_probability    = r_out_prob;
    assign o_last           = r_out_last;

`ifndef SYNTHESIS
    // The divider never runs against a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dvs != '0))
        else $error("divider running with zero divisor");

    // A result beat only follows a cycle of work
    a_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without preceding work");

    // The final beat of a run closes it
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("beat after final strategy");
`endif

endmodule
